// File: rtl/msas_pkg.sv
`default_nettype none

package msas_pkg;

    localparam int TIME_W = 32;
    localparam int ID_W   = 8;
    localparam int MASK_W = 8;

    typedef enum logic [1:0] {
        OP_ADD       = 2'd0,
        OP_CLEAR     = 2'd1,
        OP_FIRE      = 2'd2,
        OP_CLEAR_OLD = 2'd3
    } t_op;

    // One command word as it travels down the row of slot cells. The result
    // fields build up as the word passes each slot.
    typedef struct packed {
        logic              valid;
        t_op               op;
        logic [TIME_W-1:0] tref;
        logic [TIME_W-1:0] aep;
        logic              rec;
        logic [TIME_W-1:0] period;
        logic [ID_W-1:0]   slot_id;
        logic              taken;
        logic              ok;
        logic [ID_W-1:0]   slot_result;
        logic [MASK_W-1:0] fired_mask;
        logic              found;
        logic [TIME_W-1:0] best;
    } t_tok;

endpackage

`default_nettype wire

// File: rtl/msas_cell.sv
`default_nettype none

module msas_cell #(
    parameter int IDX = 0
) (
    input  wire logic          i_clk,
    input  wire logic          i_rst_n,
    input  wire msas_pkg::t_tok i_tok,
    output msas_pkg::t_tok     o_tok
);

    localparam logic [msas_pkg::ID_W-1:0] MY_ID    = msas_pkg::ID_W'(IDX);
    localparam bit                        HAS_BIT  = (IDX < msas_pkg::MASK_W);
    localparam logic [2:0]                MASK_BIT = 3'(IDX);

    logic [msas_pkg::TIME_W-1:0] r_time, n_time;
    logic                        r_en, n_en;
    logic                        r_rep, n_rep;
    logic [msas_pkg::TIME_W-1:0] r_period, n_period;
    msas_pkg::t_tok              r_tok, n_tok;
    logic [msas_pkg::TIME_W-1:0] w_sum;

    assign w_sum = i_tok.tref + r_period;

    always_comb begin
        n_time   = r_time;
        n_en     = r_en;
        n_rep    = r_rep;
        n_period = r_period;
        n_tok    = i_tok;
        if (i_tok.valid) begin
            case (i_tok.op)
                msas_pkg::OP_ADD: begin
                    // The first free slot along the row claims the new alarm.
                    if (!i_tok.taken && !r_en) begin
                        n_time            = i_tok.aep;
                        n_en              = 1'b1;
                        n_rep             = i_tok.rec;
                        n_period          = i_tok.period;
                        n_tok.taken       = 1'b1;
                        n_tok.ok          = 1'b1;
                        n_tok.slot_result = MY_ID;
                    end
                end
                msas_pkg::OP_CLEAR: begin
                    if (i_tok.slot_id == MY_ID) begin
                        n_en = 1'b0;
                    end
                end
                msas_pkg::OP_FIRE: begin
                    if (r_en && (r_time == i_tok.tref)) begin
                        n_tok.ok = 1'b1;
                        if (HAS_BIT) begin
                            n_tok.fired_mask[MASK_BIT] = 1'b1;
                        end
                        // A recurring alarm with a zero period fires only once.
                        if (r_rep && (r_period != '0)) begin
                            n_time = w_sum;
                        end else begin
                            n_en = 1'b0;
                        end
                    end
                end
                msas_pkg::OP_CLEAR_OLD: begin
                    if (r_time < i_tok.tref) begin
                        n_en = 1'b0;
                    end
                end
                default: begin
                end
            endcase
            // The search sees this slot after the command has updated it.
            if (n_en && (n_time >= i_tok.tref) && (!i_tok.found || (n_time < i_tok.best))) begin
                n_tok.found = 1'b1;
                n_tok.best  = n_time;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_time <= '0;
            r_en   <= 1'b0;
            r_rep  <= 1'b0;
            r_tok  <= '0;
        end else begin
            r_time <= n_time;
            r_en   <= n_en;
            r_rep  <= n_rep;
            r_tok  <= n_tok;
        end
    end

    always_ff @(posedge i_clk) begin
        r_period <= n_period;
    end

    assign o_tok = r_tok;

endmodule

`default_nettype wire

// File: rtl/multi_slot_alarm_scheduler.sv
`default_nettype none

// Alarm table with NUM_SLOTS slots, each held in its own cell of a row. An
// accepted command word is registered together with the recurrence period
// (unit times count), then walks the row one cell per cycle; each cell applies
// the command to its slot and folds its updated alarm into the running search
// for the earliest enabled alarm at or after the reference time. The finished
// word leaves the last cell for the output registers, and a new word is taken
// only once the previous one has left the last cell of the row. One finished
// result can wait at the output while the next command runs; a second
// finished result closes the input until the first one is taken.
module multi_slot_alarm_scheduler #(
    parameter int NUM_SLOTS = 8
) (
    input  wire logic        i_clk,
    input  wire logic        i_rst_n,
    input  wire logic        i_in_valid,
    output logic             o_in_ready,
    input  wire logic [1:0]  i_operation,
    input  wire logic [31:0] i_time_ref,
    input  wire logic [31:0] i_alarm_epoch,
    input  wire logic        i_recurring,
    input  wire logic [31:0] i_recur_unit_seconds,
    input  wire logic [31:0] i_recur_count,
    input  wire logic [7:0]  i_slot_id,
    output logic             o_out_valid,
    input  wire logic        i_out_ready,
    output logic [7:0]       o_slot_result,
    output logic             o_ok,
    output logic [7:0]       o_fired_mask,
    output logic             o_next_valid,
    output logic [31:0]      o_next_epoch
);

    localparam logic [msas_pkg::ID_W:0]   SLOT_LIMIT = (msas_pkg::ID_W + 1)'(NUM_SLOTS);
    localparam logic [msas_pkg::ID_W-1:0] FULL_ID    = msas_pkg::ID_W'(NUM_SLOTS);

    msas_pkg::t_tok              w_tok [0:NUM_SLOTS];
    logic [NUM_SLOTS:0]          w_tok_v;
    msas_pkg::t_tok              r_in_tok, n_in_tok;
    msas_pkg::t_tok              r_out, r_held;
    logic                        r_out_v, r_held_v, r_busy;
    logic                        w_in_acc, w_out_take, w_done;
    logic [msas_pkg::TIME_W-1:0] w_period;
    msas_pkg::t_op               w_op;

    assign w_op       = msas_pkg::t_op'(i_operation);
    assign w_period   = i_recur_unit_seconds * i_recur_count;
    assign o_in_ready = !r_busy && !r_held_v;
    assign w_in_acc   = i_in_valid && o_in_ready;
    assign w_out_take = r_out_v && i_out_ready;
    assign w_done     = w_tok[NUM_SLOTS].valid;

    always_comb begin
        n_in_tok             = '0;
        n_in_tok.valid       = w_in_acc;
        n_in_tok.op          = w_op;
        n_in_tok.tref        = i_time_ref;
        n_in_tok.aep         = i_alarm_epoch;
        n_in_tok.rec         = i_recurring;
        n_in_tok.period      = w_period;
        n_in_tok.slot_id     = i_slot_id;
        case (w_op)
            msas_pkg::OP_ADD: begin
                n_in_tok.slot_result = FULL_ID;
            end
            msas_pkg::OP_CLEAR: begin
                n_in_tok.ok = ({1'b0, i_slot_id} < SLOT_LIMIT);
            end
            msas_pkg::OP_CLEAR_OLD: begin
                n_in_tok.ok = 1'b1;
            end
            default: begin
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_in_tok <= '0;
            r_busy   <= 1'b0;
        end else begin
            r_in_tok <= n_in_tok;
            if (w_in_acc) begin
                r_busy <= 1'b1;
            end else if (w_done) begin
                r_busy <= 1'b0;
            end
        end
    end

    assign w_tok[0]   = r_in_tok;
    assign w_tok_v[0] = w_tok[0].valid;

    for (genvar g = 0; g < NUM_SLOTS; g++) begin : g_cell
        msas_cell #(
            .IDX(g)
        ) u_cell (
            .i_clk  (i_clk),
            .i_rst_n(i_rst_n),
            .i_tok  (w_tok[g]),
            .o_tok  (w_tok[g+1])
        );
        assign w_tok_v[g+1] = w_tok[g+1].valid;
    end

    // A finished word goes to the output register if it is free, otherwise it
    // waits in the holding register and input stays closed until it moves on.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_v  <= 1'b0;
            r_held_v <= 1'b0;
        end else begin
            if (w_done) begin
                if (!r_out_v || w_out_take) begin
                    r_out_v <= 1'b1;
                end else begin
                    r_held_v <= 1'b1;
                end
            end else if (r_held_v && (!r_out_v || w_out_take)) begin
                r_out_v  <= 1'b1;
                r_held_v <= 1'b0;
            end else if (w_out_take) begin
                r_out_v <= 1'b0;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_done) begin
            if (!r_out_v || w_out_take) begin
                r_out <= w_tok[NUM_SLOTS];
            end else begin
                r_held <= w_tok[NUM_SLOTS];
            end
        end else if (r_held_v && (!r_out_v || w_out_take)) begin
            r_out <= r_held;
        end
    end

    assign o_out_valid   = r_out_v;
    assign o_slot_result = r_out.slot_result;
    assign o_ok          = r_out.ok;
    assign o_fired_mask  = r_out.fired_mask;
    assign o_next_valid  = r_out.found;
    assign o_next_epoch  = r_out.best;

    a_one_word_in_row: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        $countones(w_tok_v) <= 1)
        else $error("more than one command word in the slot row");

    a_accept_sets_busy: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        w_in_acc |=> r_busy && w_tok[0].valid)
        else $error("accepted word did not enter the slot row");

    a_done_while_busy: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        w_done |-> r_busy && !r_held_v)
        else $error("finished word without a command in flight");

    a_held_needs_out: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_held_v |-> r_out_v)
        else $error("holding register full while output register is empty");

    a_no_epoch_without_alarm: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_out_valid && !o_next_valid) |-> (o_next_epoch == '0))
        else $error("next alarm time reported without an alarm");

endmodule

`default_nettype wire
